FILE: src/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; each macro takes a label, clock, active-low reset, antecedent and consequent
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define SMFC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("save memory port check failed");

// consequent holds in the cycle after the antecedent
`define SMFC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("save memory port check failed");

`endif

FILE: src/smfc_pkg.sv
// shared codes and constants of the save memory flash command controller
// no dependencies; used by the top level and the port checker
`default_nettype none

package smfc_pkg;

    // bus command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // save types
    localparam logic [1:0] SAVE_NONE    = 2'd0;
    localparam logic [1:0] SAVE_SRAM    = 2'd1;
    localparam logic [1:0] SAVE_FLASH64 = 2'd2;
    localparam logic [1:0] SAVE_FLASH128 = 2'd3;

    // access widths, any other code reads as word
    localparam logic [1:0] WID_BYTE = 2'd0;
    localparam logic [1:0] WID_HALF = 2'd1;

    // unlock sequence
    localparam logic [15:0] UNLOCK_ADDR1 = 16'h5555;
    localparam logic [15:0] UNLOCK_ADDR2 = 16'h2AAA;
    localparam logic [7:0]  UNLOCK_DATA1 = 8'hAA;
    localparam logic [7:0]  UNLOCK_DATA2 = 8'h55;

    // flash command bytes
    localparam logic [7:0] FC_ID_ON       = 8'h90;
    localparam logic [7:0] FC_ID_OFF      = 8'hF0;
    localparam logic [7:0] FC_ERASE_ARM   = 8'h80;
    localparam logic [7:0] FC_PROGRAM     = 8'hA0;
    localparam logic [7:0] FC_BANK_SELECT = 8'hB0;
    localparam logic [7:0] FC_CHIP_ERASE  = 8'h10;
    localparam logic [7:0] FC_SECTOR_ERASE = 8'h30;

    // chip id bytes
    localparam logic [7:0] ID128_MAKER  = 8'hC2;
    localparam logic [7:0] ID128_DEVICE = 8'h09;
    localparam logic [7:0] ID64_MAKER   = 8'hBF;
    localparam logic [7:0] ID64_DEVICE  = 8'hD4;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // physical offset width and width of erase span arithmetic
    localparam int OFF_W  = 17;
    localparam int SPAN_W = 18;

endpackage

`default_nettype wire

FILE: src/save_memory_flash_command_controller.sv
// top level of the save memory flash command controller: byte store, command decode, erase sweep
// depends on smfc_pkg
`default_nettype none

// Byte-wide save memory behind a start/busy command port. A command is taken when start is
// high and busy low. Writes and clear-dirty give their result strobe in the next cycle and,
// unless they start an erase, the port is free again at once; a read goes through the
// synchronous store read and then the register that forms the replicated word before its
// strobe. The result is on read_data and save_dirty for exactly one cycle under result_valid
// and must be taken then. The store is one single-port byte memory, so erasing is a sweep of
// one byte per cycle with busy high: after reset and after every save type write, and on chip
// erase, over the whole store; on sector erase, over the part of the sector inside the store,
// after the sector is located in S_FIND and S_PLAN. The result of an erase command comes in
// the first cycle of the erase. Save type writes are taken during an erase (a full sweep then
// restarts) and whenever the block is idle with start low.
module save_memory_flash_command_controller
    import smfc_pkg::*;
#(
    parameter int STORE_BYTES  = 131072,
    parameter int SECTOR_BYTES = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic [1:0]  width,
    output logic             result_valid,
    output logic [31:0]      read_data,
    output logic             save_dirty,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data
);

    localparam int IDX_W = $clog2(STORE_BYTES);
    localparam logic [SPAN_W-1:0] STORE_END  = SPAN_W'(STORE_BYTES);
    localparam logic [SPAN_W-1:0] SECTOR_SZ  = SPAN_W'(SECTOR_BYTES);

    // reciprocal of the sector size, exact for every 16-bit address
    localparam int SEC_LOG     = $clog2(SECTOR_BYTES);
    localparam int RECIP_SHIFT = 16 + SEC_LOG;
    localparam logic [16:0] SEC_RECIP =
        17'(((64'd1 << RECIP_SHIFT) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES));

    typedef enum logic [2:0] {S_IDLE, S_READ, S_FIND, S_PLAN, S_SWEEP} state_t;
    typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_CMD, PH_EXT} phase_t;

    function automatic logic [31:0] replicate(input logic [7:0] b, input logic [1:0] w);
        logic [31:0] r;
        unique case (w)
            WID_BYTE: r = {24'h0, b};
            WID_HALF: r = {16'h0, b, b};
            default:  r = {b, b, b, b};
        endcase
        return r;
    endfunction

    // byte store
    logic [7:0]       store [STORE_BYTES];
    logic [7:0]       mem_rd_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_idx;
    logic [7:0]       mem_wd;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [1:0]  mode_reg, mode_next;
    logic        chip_id_reg, chip_id_next;
    logic        erase_arm_reg, erase_arm_next;
    logic        prog_arm_reg, prog_arm_next;
    logic        bank_arm_reg, bank_arm_next;
    logic        bank_reg, bank_next;
    logic        dirty_reg, dirty_next;
    logic        result_valid_reg, result_valid_next;
    logic [31:0] read_data_reg, read_data_next;
    logic [15:0] addr_reg, addr_next;
    logic        rd_mem_reg, rd_mem_next;
    logic        rd_ones_reg, rd_ones_next;
    logic [7:0]  rd_byte_reg, rd_byte_next;
    logic [1:0]  rd_width_reg, rd_width_next;
    logic [SPAN_W-1:0] sec_base_reg, sec_base_next;
    logic [SPAN_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [SPAN_W-1:0] sweep_end_reg, sweep_end_next;

    logic              accept;
    logic              cfg_fire;
    logic              is_flash;
    logic              bank_sel;
    logic [OFF_W-1:0]  phys_off;
    logic              phys_in_range;
    logic [IDX_W-1:0]  acc_idx;
    logic [32:0]       sec_prod;
    logic [SPAN_W-1:0] sec_aligned;
    logic [SPAN_W-1:0] phys_base;
    logic [SPAN_W-1:0] end_raw;
    logic [SPAN_W-1:0] sweep_inc;
    logic [7:0]        rd_src;

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign cfg_ready    = (state_reg == S_FIND) || (state_reg == S_PLAN)
                          || (state_reg == S_SWEEP) || ((state_reg == S_IDLE) && !start);
    assign cfg_fire     = cfg_valid && cfg_ready;
    assign result_valid = result_valid_reg;
    assign read_data    = read_data_reg;
    assign save_dirty   = dirty_reg;

    assign is_flash      = (mode_reg == SAVE_FLASH64) || (mode_reg == SAVE_FLASH128);
    assign bank_sel      = (mode_reg == SAVE_FLASH128) && bank_reg;
    assign phys_off      = {bank_sel, address};
    assign phys_in_range = SPAN_W'(phys_off) < STORE_END;
    assign acc_idx       = (mode_reg == SAVE_SRAM) ? IDX_W'(address[14:0])
                                                   : phys_off[IDX_W-1:0];

    assign sec_prod    = {17'h0, addr_reg} * {16'h0, SEC_RECIP};
    assign sec_aligned = sec_base_reg * SECTOR_SZ;
    assign phys_base   = SPAN_W'({bank_sel, 16'h0}) + sec_aligned;
    assign end_raw     = phys_base + SECTOR_SZ;
    assign sweep_inc   = sweep_addr_reg + SPAN_W'(1);
    assign rd_src      = rd_mem_reg ? mem_rd_reg : rd_byte_reg;

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        mode_next         = mode_reg;
        chip_id_next      = chip_id_reg;
        erase_arm_next    = erase_arm_reg;
        prog_arm_next     = prog_arm_reg;
        bank_arm_next     = bank_arm_reg;
        bank_next         = bank_reg;
        dirty_next        = dirty_reg;
        result_valid_next = 1'b0;
        read_data_next    = read_data_reg;
        addr_next         = addr_reg;
        rd_mem_next       = rd_mem_reg;
        rd_ones_next      = rd_ones_reg;
        rd_byte_next      = rd_byte_reg;
        rd_width_next     = rd_width_reg;
        sec_base_next     = sec_base_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_end_next    = sweep_end_reg;
        mem_we            = 1'b0;
        mem_idx           = acc_idx;
        mem_wd            = write_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next = address;
                    unique case (command)
                        CMD_READ:
                        begin
                            state_next    = S_READ;
                            rd_width_next = width;
                            rd_ones_next  = (mode_reg == SAVE_NONE);
                            rd_mem_next   = 1'b1;
                            rd_byte_next  = ERASED_BYTE;
                            if (is_flash)
                            begin
                                if (chip_id_reg && (address[15:1] == 15'h0))
                                begin
                                    rd_mem_next = 1'b0;
                                    if (mode_reg == SAVE_FLASH128)
                                        rd_byte_next = address[0] ? ID128_DEVICE : ID128_MAKER;
                                    else
                                        rd_byte_next = address[0] ? ID64_DEVICE : ID64_MAKER;
                                end
                                else if (!phys_in_range)
                                begin
                                    rd_mem_next = 1'b0;
                                end
                            end
                        end
                        CMD_WRITE:
                        begin
                            result_valid_next = 1'b1;
                            read_data_next    = '0;
                            if (mode_reg == SAVE_SRAM)
                            begin
                                mem_we     = 1'b1;
                                dirty_next = 1'b1;
                            end
                            else if (is_flash)
                            begin
                                unique case (phase_reg)
                                    PH_IDLE:
                                    begin
                                        if (address == UNLOCK_ADDR1 && write_data == UNLOCK_DATA1)
                                            phase_next = PH_FIRST;
                                    end
                                    PH_FIRST:
                                    begin
                                        if (address == UNLOCK_ADDR2 && write_data == UNLOCK_DATA2)
                                            phase_next = PH_CMD;
                                        else
                                            phase_next = PH_IDLE;
                                    end
                                    PH_CMD:
                                    begin
                                        phase_next = PH_IDLE;
                                        unique case (write_data)
                                            FC_ID_ON:     chip_id_next   = 1'b1;
                                            FC_ID_OFF:    chip_id_next   = 1'b0;
                                            FC_ERASE_ARM: erase_arm_next = 1'b1;
                                            FC_PROGRAM:
                                            begin
                                                prog_arm_next = 1'b1;
                                                phase_next    = PH_EXT;
                                            end
                                            FC_BANK_SELECT:
                                            begin
                                                if (mode_reg == SAVE_FLASH128)
                                                begin
                                                    bank_arm_next = 1'b1;
                                                    phase_next    = PH_EXT;
                                                end
                                            end
                                            FC_CHIP_ERASE:
                                            begin
                                                if (erase_arm_reg)
                                                begin
                                                    erase_arm_next  = 1'b0;
                                                    dirty_next      = 1'b1;
                                                    sweep_addr_next = '0;
                                                    sweep_end_next  = STORE_END;
                                                    state_next      = S_SWEEP;
                                                end
                                            end
                                            FC_SECTOR_ERASE:
                                            begin
                                                if (erase_arm_reg)
                                                begin
                                                    erase_arm_next = 1'b0;
                                                    dirty_next     = 1'b1;
                                                    sec_base_next  = '0;
                                                    state_next     = S_FIND;
                                                end
                                            end
                                            default:
                                            begin
                                            end
                                        endcase
                                    end
                                    PH_EXT:
                                    begin
                                        phase_next = PH_IDLE;
                                        // program wins over bank select
                                        if (prog_arm_reg)
                                        begin
                                            prog_arm_next = 1'b0;
                                            if (phys_in_range)
                                            begin
                                                mem_we     = 1'b1;
                                                dirty_next = 1'b1;
                                            end
                                        end
                                        else if (bank_arm_reg)
                                        begin
                                            bank_arm_next = 1'b0;
                                            bank_next     = write_data[0];
                                        end
                                    end
                                endcase
                            end
                        end
                        CMD_CLEAR:
                        begin
                            result_valid_next = 1'b1;
                            read_data_next    = '0;
                            dirty_next        = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                result_valid_next = 1'b1;
                read_data_next    = rd_ones_reg ? 32'hFFFF_FFFF : replicate(rd_src, rd_width_reg);
                state_next        = S_IDLE;
            end
            S_FIND:
            begin
                // sector number of the address by reciprocal multiplication
                sec_base_next = SPAN_W'(sec_prod >> RECIP_SHIFT);
                state_next    = S_PLAN;
            end
            S_PLAN:
            begin
                if (phys_base < STORE_END)
                begin
                    sweep_addr_next = phys_base;
                    sweep_end_next  = (end_raw > STORE_END) ? STORE_END : end_raw;
                    state_next      = S_SWEEP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                mem_we          = 1'b1;
                mem_idx         = sweep_addr_reg[IDX_W-1:0];
                mem_wd          = ERASED_BYTE;
                sweep_addr_next = sweep_inc;
                if (sweep_inc == sweep_end_reg)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a save type write resets the flash state and erases the whole store
        if (cfg_fire)
        begin
            mode_next       = cfg_data;
            phase_next      = PH_IDLE;
            chip_id_next    = 1'b0;
            erase_arm_next  = 1'b0;
            prog_arm_next   = 1'b0;
            bank_arm_next   = 1'b0;
            bank_next       = 1'b0;
            sweep_addr_next = '0;
            sweep_end_next  = STORE_END;
            state_next      = S_SWEEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            phase_reg        <= PH_IDLE;
            mode_reg         <= SAVE_NONE;
            chip_id_reg      <= 1'b0;
            erase_arm_reg    <= 1'b0;
            prog_arm_reg     <= 1'b0;
            bank_arm_reg     <= 1'b0;
            bank_reg         <= 1'b0;
            dirty_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            sec_base_reg     <= '0;
            sweep_addr_reg   <= '0;
            sweep_end_reg    <= STORE_END;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            mode_reg         <= mode_next;
            chip_id_reg      <= chip_id_next;
            erase_arm_reg    <= erase_arm_next;
            prog_arm_reg     <= prog_arm_next;
            bank_arm_reg     <= bank_arm_next;
            bank_reg         <= bank_next;
            dirty_reg        <= dirty_next;
            result_valid_reg <= result_valid_next;
            sec_base_reg     <= sec_base_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_end_reg    <= sweep_end_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        addr_reg      <= addr_next;
        rd_mem_reg    <= rd_mem_next;
        rd_ones_reg   <= rd_ones_next;
        rd_byte_reg   <= rd_byte_next;
        rd_width_reg  <= rd_width_next;
    end

    // single-port store, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_idx] <= mem_wd;
        else
            mem_rd_reg <= store[mem_idx];
    end

endmodule

`default_nettype wire

FILE: src/smfc_checker.sv
// port-level checker for the save memory flash command controller, bound to the top level
// depends on smfc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module smfc_checker
    import smfc_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] command,
    input wire logic       result_valid,
    input wire logic       save_dirty,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready
);

    logic cmd_beat;
    logic read_beat;
    logic reply_beat;
    logic clear_beat;

    assign cmd_beat   = start && !busy;
    assign read_beat  = cmd_beat && (command == CMD_READ);
    assign clear_beat = cmd_beat && (command == CMD_CLEAR);
    assign reply_beat = cmd_beat && (command == CMD_WRITE || command == CMD_CLEAR);

    // write and clear answer in the next cycle
    `SMFC_ASSERT_NEXT(a_write_result, clk, rst_n, reply_beat, result_valid)

    // a read answers after its beat has passed the store read and the result register
    `SMFC_ASSERT_NEXT(a_read_result, clk, rst_n, $past(read_beat), result_valid)

    // no result without a matching command beat
    `SMFC_ASSERT_SAME(a_no_spurious, clk, rst_n, result_valid, $past(cmd_beat) || $past(read_beat, 2))

    `SMFC_ASSERT_NEXT(a_clear_dirty, clk, rst_n, clear_beat, !save_dirty)

    // a save type write always starts an erase sweep
    `SMFC_ASSERT_NEXT(a_cfg_sweep, clk, rst_n, cfg_valid && cfg_ready, busy)

endmodule

bind save_memory_flash_command_controller smfc_checker u_smfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .save_dirty   (save_dirty),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire
